### rtl/lbo_pkg.sv
// lbo_pkg: shared types and constants of the label boundary overlay block
// used by label_boundary_overlay and lbo_checker, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lbo_pkg;

    // widths fixed by the pixel and register formats
    localparam int CFG_W      = 12;
    localparam int IN_LABEL_W = 16;
    localparam int COL_W      = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int LABEL_BITS_DEF = 16;

    // register reset values
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    // register index codes (taken from the top address bit)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // colour of a border pixel
    localparam logic [COL_W-1:0] WHITE = 8'hFF;

    typedef struct packed {
        logic [IN_LABEL_W-1:0] pixel_label;
        logic [COL_W-1:0]      in_red;
        logic [COL_W-1:0]      in_green;
        logic [COL_W-1:0]      in_blue;
        logic                  drain;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0] out_red;
        logic [COL_W-1:0] out_green;
        logic [COL_W-1:0] out_blue;
        logic             is_border;
        logic             frame_last;
    } t_out_word;

endpackage

`default_nettype wire

### rtl/label_boundary_overlay.sv
// label_boundary_overlay: 8-connected segment border overlay on a colour stream
// depends on lbo_pkg for word types, register codes and constants
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel (i_valid / o_ready / i_data): one word per pixel in raster
//   order, carrying label and rgb colour; after each frame the source sends
//   width+1 words with drain set to flush the window
//   output channel (o_valid / i_ready / o_data): zero or one word per input
//   word; border pixels come out white with is_border set, others keep their
//   colour; frame_last marks the last pixel of the frame
//   configuration: apb-style port, image_width at 0x0, image_height at 0x4;
//   a write returns the stream position to the start of a frame
// throughput and latency
//   one word per cycle if unstalled; each column does one read and one write of
//   the line memories per word (read issued on accept, write-back one stage
//   later, a forward path covers back-to-back words on the same column)
//   a pixel's result is released by the input word one line and one pixel
//   later; that word waits in stage a and the result is registered on o_data
//   when stage a fires, which a stalled output register can hold back
// reset and stall
//   reset clears position, window and handshake state; line memories are not
//   cleared, their stale entries only feed edge pixels
//   when the receiver stalls the output register holds its word, the input
//   stage keeps accepting until it also holds a word, then o_ready drops

module label_boundary_overlay #(
    parameter int MAX_WIDTH  = lbo_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = lbo_pkg::LABEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input
    input  logic                         i_valid,
    output logic                         o_ready,
    input  lbo_pkg::t_in_word            i_data,
    // result output
    output logic                         o_valid,
    input  logic                         i_ready,
    output lbo_pkg::t_out_word           o_data,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbo_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbo_pkg::PDATA_W-1:0]  pwdata,
    output logic [lbo_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = (LABEL_BITS < lbo_pkg::IN_LABEL_W) ? LABEL_BITS : lbo_pkg::IN_LABEL_W;
    localparam int WW = (XW + 1 > lbo_pkg::CFG_W) ? XW + 1 : lbo_pkg::CFG_W;
    localparam int YW = lbo_pkg::CFG_W + 1;
    localparam int CW = 3 * lbo_pkg::COL_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [lbo_pkg::CFG_W-1:0] r_width;
    logic [lbo_pkg::CFG_W-1:0] r_height;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lbo_pkg::RESET_WIDTH;
            r_height <= lbo_pkg::RESET_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[lbo_pkg::PADDR_W-1])
                lbo_pkg::REG_WIDTH:  r_width  <= pwdata[lbo_pkg::CFG_W-1:0];
                lbo_pkg::REG_HEIGHT: r_height <= pwdata[lbo_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[lbo_pkg::PADDR_W-1])
            lbo_pkg::REG_WIDTH:  prdata = lbo_pkg::PDATA_W'(r_width);
            lbo_pkg::REG_HEIGHT: prdata = lbo_pkg::PDATA_W'(r_height);
            default:             prdata = '0;
        endcase
    end

    // effective frame size: zero means one, width saturates at the line length
    logic [WW-1:0]             w_ext;
    logic [XW-1:0]             w_m1;
    logic [lbo_pkg::CFG_W-1:0] h_eff;
    logic [YW-1:0]             h_ext;
    logic [YW-1:0]             h_p1;

    assign w_ext = WW'(r_width);

    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = XW'(w_ext - WW'(1));
        end
    end

    assign h_eff = (r_height == '0) ? lbo_pkg::CFG_W'(1) : r_height;
    assign h_ext = YW'(h_eff);
    assign h_p1  = h_ext + YW'(1);

    // ------------------------------------------------------------------
    // stream position and per-word decode at accept
    // ------------------------------------------------------------------
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic          accept;
    logic          fire;
    logic          x_zero;
    logic          dec_emit;
    logic          dec_edge;
    logic          dec_last;
    logic          in_frame;

    assign accept = i_valid & o_ready;
    assign x_zero = (r_x == '0);

    // column zero releases the last pixel of the line two rows up,
    // other columns release the previous column of the row above
    always_comb begin
        if (x_zero) begin
            dec_emit = (r_y >= YW'(2)) && (r_y <= h_p1);
        end else begin
            dec_emit = (r_y >= YW'(1)) && (r_y <= h_ext);
        end
        // right column, left column, top row or bottom row
        dec_edge = x_zero || (r_x == XW'(1)) || (r_y == YW'(1)) || (r_y == h_ext);
        dec_last = x_zero && (r_y == h_p1);
        in_frame = (r_y < h_ext) && !i_data.drain;
    end

    always_comb begin
        if (dec_last) begin
            n_x = '0;
            n_y = '0;
        end else if (r_x == w_m1) begin
            n_x = '0;
            n_y = r_y + YW'(1);
        end else begin
            n_x = r_x + XW'(1);
            n_y = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (cfg_wr) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // ------------------------------------------------------------------
    // line memories: one word per column
    //   label word = {row above, two rows above}, colour word = row above
    // ------------------------------------------------------------------
    logic [2*LW-1:0] r_lab_mem [MAX_WIDTH];
    logic [CW-1:0]   r_col_mem [MAX_WIDTH];
    logic [2*LW-1:0] r_lab_rd;
    logic [CW-1:0]   r_col_rd;

    // stage a: accepted word waiting for its memory data
    logic            r_a_valid;
    logic [XW-1:0]   r_a_x;
    logic [LW-1:0]   r_a_lab;
    logic [CW-1:0]   r_a_col;
    logic            r_a_emit;
    logic            r_a_edge;
    logic            r_a_last;

    // forward of a write-back that coincided with the read of the same column
    logic            r_fwd;
    logic [2*LW-1:0] r_fwd_lab;
    logic [CW-1:0]   r_fwd_col;

    logic [2*LW-1:0] rd_lab;
    logic [CW-1:0]   old_col;
    logic [LW-1:0]   up2;
    logic [LW-1:0]   up1;
    logic [2*LW-1:0] wr_lab;

    logic            r_out_valid;
    lbo_pkg::t_out_word r_out;

    assign fire    = r_a_valid & (!r_out_valid | i_ready);
    assign o_ready = !r_a_valid | fire;

    assign rd_lab  = r_fwd ? r_fwd_lab : r_lab_rd;
    assign old_col = r_fwd ? r_fwd_col : r_col_rd;
    assign up2     = rd_lab[LW-1:0];
    assign up1     = rd_lab[2*LW-1:LW];
    assign wr_lab  = {r_a_lab, up1};

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_lab_mem[r_a_x] <= wr_lab;
            r_col_mem[r_a_x] <= r_a_col;
        end
        if (accept) begin
            r_lab_rd <= r_lab_mem[r_x];
            r_col_rd <= r_col_mem[r_x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_fwd     <= fire && (r_a_x == r_x);
            end else if (fire) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x     <= r_x;
            r_a_lab   <= in_frame ? i_data.pixel_label[LW-1:0] : '0;
            r_a_col   <= in_frame ? {i_data.in_red, i_data.in_green, i_data.in_blue} : '0;
            r_a_emit  <= dec_emit;
            r_a_edge  <= dec_edge;
            r_a_last  <= dec_last;
            r_fwd_lab <= wr_lab;
            r_fwd_col <= r_a_col;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 label window and colour delay, advanced when stage a fires
    //   column 0 oldest, row 0 two rows above
    // ------------------------------------------------------------------
    logic [LW-1:0] r_win [3][3];
    logic [LW-1:0] n_win [3][3];
    logic [CW-1:0] r_cdelay;
    logic          differ;
    logic          border;
    lbo_pkg::t_out_word n_out;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = up2;
        n_win[1][2] = up1;
        n_win[2][2] = r_a_lab;
    end

    always_comb begin
        differ = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (n_win[r][c] != n_win[1][1]) begin
                    differ = 1'b1;
                end
            end
        end
        border = r_a_edge | differ;
    end

    always_comb begin
        n_out.out_red    = border ? lbo_pkg::WHITE : r_cdelay[CW-1:2*lbo_pkg::COL_W];
        n_out.out_green  = border ? lbo_pkg::WHITE
                                  : r_cdelay[2*lbo_pkg::COL_W-1:lbo_pkg::COL_W];
        n_out.out_blue   = border ? lbo_pkg::WHITE : r_cdelay[lbo_pkg::COL_W-1:0];
        n_out.is_border  = border;
        n_out.frame_last = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '{default: '0};
            r_cdelay <= '0;
        end else if (fire) begin
            r_win    <= n_win;
            r_cdelay <= old_col;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_a_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_a_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### rtl/lbo_checker.sv
// lbo_checker: port-level assertions for label_boundary_overlay, bound to it
// depends on lbo_pkg for the output word type
`timescale 1ns / 1ps
`default_nettype none

module lbo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input lbo_pkg::t_out_word o_data
);

    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    // border pixels are white
    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_border |->
            o_data.out_red == lbo_pkg::WHITE && o_data.out_green == lbo_pkg::WHITE &&
            o_data.out_blue == lbo_pkg::WHITE)
        else $error("border pixel not white");

    // last pixel is a corner, hence a border
    a_last_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_last |-> o_data.is_border)
        else $error("frame_last on a non-border pixel");

    // no output word right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind label_boundary_overlay lbo_checker u_lbo_checker (.*);

`default_nettype wire
